@@ hw/rtl/hdr10_pixel_to_srgb8_top_defines.svh @@
// Assertion macros for the HDR10 pixel converter
`ifndef HDR10_PIXEL_TO_SRGB8_TOP_DEFINES_SVH
`define HDR10_PIXEL_TO_SRGB8_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("hdr10 pixel converter: check failed");

// consequent holds in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hdr10 pixel converter: check failed");

// consequent holds in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hdr10 pixel converter: check failed");

`else

`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/hdrp_pkg.sv @@
// Shared constants, curve tables and stage map for the HDR10 pixel converter
`default_nettype none

package hdrp_pkg;

  // pipeline map: stage 0 is the PQ lookup, the rest live in each colour lane
  localparam int DIV_STAGES    = 17;
  localparam int SEARCH_STAGES = 8;
  localparam int ST_PROD       = 1;
  localparam int ST_SUM        = 2;
  localparam int ST_DIV0       = 3;
  localparam int ST_LIN        = ST_DIV0 + DIV_STAGES + 1;
  localparam int ST_SRCH       = ST_LIN + 1;
  localparam int NSTAGE        = ST_SRCH + SEARCH_STAGES;

  localparam int PQ_W    = 30;   // nits in Q14.16, at most 10000.0
  localparam int COEF_W  = 22;   // matrix coefficients in Q.20, signed
  localparam int PROD_W  = 53;
  localparam int LIN_W   = 17;   // 0..65536
  localparam int WHITE_W = 14;
  localparam int FRAC_LOG = 28;

  localparam logic [LIN_W-1:0] LIN_FULL = 17'd65536;

  // register map, selected by paddr[2]
  localparam logic REG_HDR10_ENABLE = 1'b0;
  localparam logic REG_PAPER_WHITE  = 1'b1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [PQ_W-1:0]  pq_table_t  [1024];
  typedef logic [LIN_W-1:0] thr_table_t [256];

  // Rec.2020 to Rec.709, rows are output red, green, blue
  localparam coef_t COEF [3][3] = '{
    '{ 22'sd1741151, -22'sd616186,  -22'sd76389  },
    '{-22'sd130600,   22'sd1187932, -22'sd8755   },
    '{-22'sd19033,   -22'sd105465,   22'sd1173073}
  };

  // ---- elaboration-time curve arithmetic ----

  // log2 in Q28 by repeated squaring
  function automatic logic [63:0] fx_log2(input logic [63:0] x);
    logic [63:0] m;
    logic [63:0] f;
    int n;
    int i;
    f = '0;
    n = 0;
    if (x == 64'd0) return 64'd0;
    for (i = 0; i < 64; i++) if (x[i]) n = i;
    if (n >= 30) m = x >> (n - 30);
    else m = x << (30 - n);
    for (i = 1; i <= FRAC_LOG; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f[FRAC_LOG - i] = 1'b1;
      end
    end
    return (64'(n) << FRAC_LOG) | f;
  endfunction

  // 2^-t, t in Q28, result in Q30, by a 20-term series
  function automatic logic [63:0] fx_exp2_neg(input logic [63:0] t);
    logic [63:0] ip;
    logic [63:0] fp;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] prod;
    longint sum;
    int k;
    ip = t >> FRAC_LOG;
    fp = t & 64'h0FFF_FFFF;
    z = (fp * 64'd744261118) >> FRAC_LOG;
    term = 64'd1 << 30;
    sum = longint'(64'd1 << 30);
    if (ip >= 64'd40) return 64'd0;
    for (k = 1; k <= 20; k++) begin
      prod = (term * z) >> 30;
      case (k)
        1:  term = prod;
        2:  term = prod / 64'd2;
        3:  term = prod / 64'd3;
        4:  term = prod / 64'd4;
        5:  term = prod / 64'd5;
        6:  term = prod / 64'd6;
        7:  term = prod / 64'd7;
        8:  term = prod / 64'd8;
        9:  term = prod / 64'd9;
        10: term = prod / 64'd10;
        11: term = prod / 64'd11;
        12: term = prod / 64'd12;
        13: term = prod / 64'd13;
        14: term = prod / 64'd14;
        15: term = prod / 64'd15;
        16: term = prod / 64'd16;
        17: term = prod / 64'd17;
        18: term = prod / 64'd18;
        19: term = prod / 64'd19;
        default: term = prod / 64'd20;
      endcase
      if (k[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return unsigned'(sum) >> ip;
  endfunction

  // ST 2084 decode of one 10-bit code to nits in Q14.16
  function automatic logic [PQ_W-1:0] pq_entry(input int c);
    logic [63:0] mag;
    logic [63:0] ep;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] y;
    logic [63:0] lgn;
    logic [63:0] lgd;
    logic [63:0] res;
    if (c == 0) return '0;
    mag = fx_log2(64'd1023) - fx_log2(64'(c));
    ep = fx_exp2_neg(mag * 64'd32 / 64'd2523);
    if (ep <= (64'd3424 << 18)) return '0;
    num = ep - (64'd3424 << 18);
    den = (64'd2413 << 23) - ((64'd2392 * ep) >> 7);
    lgn = fx_log2(num);
    lgd = fx_log2(den);
    mag = (lgd > lgn) ? (lgd - lgn) : 64'd0;
    y = fx_exp2_neg(mag * 64'd8192 / 64'd1305);
    res = (y * 64'd10000 + 64'd8192) >> 14;
    return res[PQ_W-1:0];
  endfunction

  // sRGB encode of linear Q0.16, result Q0.16
  function automatic logic [63:0] srgb_entry(input logic [63:0] v);
    logic [63:0] p;
    longint s;
    if (v <= 64'd205) return (64'd1292 * v + 64'd50) / 64'd100;
    p = fx_exp2_neg(((64'd16 << FRAC_LOG) - fx_log2(v)) * 64'd5 / 64'd12);
    s = (longint'(64'd1055 * p) - 64'sd59055800320 + 64'sd8192000) / 64'sd16384000;
    if (s < 0) s = 0;
    if (s > 65536) s = 65536;
    return unsigned'(s);
  endfunction

  function automatic logic [63:0] srgb_byte(input logic [63:0] v);
    return (srgb_entry(v) * 64'd255 + 64'd32768) >> 16;
  endfunction

  function automatic pq_table_t build_pq_table();
    pq_table_t tbl;
    int i;
    for (i = 0; i < 1024; i++) tbl[i] = pq_entry(i);
    return tbl;
  endfunction

  // entry k: smallest linear value whose encoded byte reaches k
  function automatic thr_table_t build_thr_table();
    thr_table_t tbl;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    int k;
    int i;
    tbl[0] = '0;
    for (k = 1; k < 256; k++) begin
      lo = 64'd0;
      hi = 64'd65536;
      for (i = 0; i < LIN_W; i++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (srgb_byte(mid) >= 64'(k)) hi = mid;
          else lo = mid + 64'd1;
        end
      end
      tbl[k] = lo[LIN_W-1:0];
    end
    return tbl;
  endfunction

  localparam pq_table_t  PQ_TABLE  = build_pq_table();
  localparam thr_table_t THR_TABLE = build_thr_table();

endpackage

`default_nettype wire

@@ hw/rtl/hdrp_chan.sv @@
// One colour lane: matrix row, paper-white divide, clamp and sRGB byte search
`default_nettype none

module hdrp_chan (
  input  logic                          clk,
  input  logic [hdrp_pkg::NSTAGE-1:0]   load,
  input  hdrp_pkg::coef_t               coef_r,
  input  hdrp_pkg::coef_t               coef_g,
  input  hdrp_pkg::coef_t               coef_b,
  input  logic [hdrp_pkg::WHITE_W-1:0]  white,
  input  logic [hdrp_pkg::PQ_W-1:0]     pq_r,
  input  logic [hdrp_pkg::PQ_W-1:0]     pq_g,
  input  logic [hdrp_pkg::PQ_W-1:0]     pq_b,
  output logic [7:0]                    chan_byte
);
  import hdrp_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_g;
  logic signed [PROD_W-1:0] prod_b;
  logic signed [PROD_W-1:0] acc_sum;
  logic signed [PROD_W-1:0] round_sum;
  logic [30:0]              quo_in;

  logic [WHITE_W-1:0] dv_rem [DIV_STAGES+1];
  logic [LIN_W-1:0]   dv_q   [DIV_STAGES+1];
  logic               dv_ovf [DIV_STAGES+1];
  logic [LIN_W-1:0]   dv_low [DIV_STAGES];
  logic [LIN_W-1:0]   lin;

  logic [7:0]         sr_acc [SEARCH_STAGES];
  logic [LIN_W-1:0]   sr_lin [SEARCH_STAGES-1];

  // three products of the matrix row
  always_ff @(posedge clk) begin
    if (load[ST_PROD]) begin
      prod_r <= coef_r * $signed({1'b0, pq_r});
      prod_g <= coef_g * $signed({1'b0, pq_g});
      prod_b <= coef_b * $signed({1'b0, pq_b});
    end
  end

  always_ff @(posedge clk) begin
    if (load[ST_SUM]) begin
      acc_sum <= prod_r + prod_g + prod_b;
    end
  end

  // round by half the divisor, drop 20 fraction bits; non-positive gives zero
  assign round_sum = acc_sum + $signed({20'd0, white, 19'd0});
  assign quo_in    = (acc_sum > 0) ? round_sum[50:20] : 31'd0;

  always_ff @(posedge clk) begin
    if (load[ST_DIV0]) begin
      dv_rem[0] <= quo_in[30:17];
      dv_low[0] <= quo_in[16:0];
      dv_q[0]   <= '0;
      dv_ovf[0] <= (quo_in[30:17] >= white);
    end
  end

  // restoring divide, one quotient bit a stage
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [WHITE_W:0] trial;
    logic             fits;
    assign trial = {dv_rem[j], dv_low[j][LIN_W-1]};
    assign fits  = (trial >= {1'b0, white});
    always_ff @(posedge clk) begin
      if (load[ST_DIV0+1+j]) begin
        dv_rem[j+1] <= fits ? WHITE_W'(trial - {1'b0, white}) : trial[WHITE_W-1:0];
        dv_q[j+1]   <= {dv_q[j][LIN_W-2:0], fits};
        dv_ovf[j+1] <= dv_ovf[j];
      end
    end
    if (j < DIV_STAGES - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (load[ST_DIV0+1+j]) begin
          dv_low[j+1] <= {dv_low[j][LIN_W-2:0], 1'b0};
        end
      end
    end
  end

  // clamp to full white
  always_ff @(posedge clk) begin
    if (load[ST_LIN]) begin
      lin <= (dv_ovf[DIV_STAGES] || dv_q[DIV_STAGES] > LIN_FULL) ? LIN_FULL
                                                                   : dv_q[DIV_STAGES];
    end
  end

  // binary search of the encode thresholds, one byte bit a stage
  for (genvar s = 0; s < SEARCH_STAGES; s++) begin : g_srch
    logic [7:0]       prev_acc;
    logic [LIN_W-1:0] prev_lin;
    logic [7:0]       cand;
    if (s == 0) begin : g_first
      assign prev_acc = 8'd0;
      assign prev_lin = lin;
    end else begin : g_rest
      assign prev_acc = sr_acc[s-1];
      assign prev_lin = sr_lin[s-1];
    end
    assign cand = prev_acc | (8'd1 << (SEARCH_STAGES - 1 - s));
    always_ff @(posedge clk) begin
      if (load[ST_SRCH+s]) begin
        sr_acc[s] <= (prev_lin >= THR_TABLE[cand]) ? cand : prev_acc;
      end
    end
    if (s < SEARCH_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (load[ST_SRCH+s]) begin
          sr_lin[s] <= prev_lin;
        end
      end
    end
  end

  assign chan_byte = sr_acc[SEARCH_STAGES-1];

endmodule

`default_nettype wire

@@ hw/rtl/hdr10_pixel_to_srgb8_top.sv @@
// Top level of the HDR10 10:10:10:2 pixel to 8-bit sRGBA converter
//
// Pixel channel: packed_pixel with pixel_valid / pixel_ready; one beat is one
// pixel, red in bits 9:0. Result channel: four bytes with result_valid /
// result_ready, one beat per pixel, in order.
// Throughput: one pixel a clock while result_ready is high. There are 30
// register stages (the first loads at the accepting edge): PQ ROM, matrix
// products, row sum, divide set-up, 17 one-bit divide steps for the
// paper-white scaling, clamp, and 8 steps of threshold search for the sRGB
// byte.
// Each stage holds its beat only while the stage after it is full and
// stalled, so a stalled receiver backs the pipe up stage by stage and empty
// slots are squeezed out; pixel_ready falls only once every stage is full.
// Reset empties the pipe and sets hdr10_enable to 0 and paper_white_nits to
// 300. The APB port (registers at 0 and 4) is to be written only while the
// pipe is empty (the block does not check); a zero paper white is used as one.
`default_nettype none

`include "hdr10_pixel_to_srgb8_top_defines.svh"

module hdr10_pixel_to_srgb8_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        pixel_valid,
  output logic        pixel_ready,
  input  logic [31:0] packed_pixel,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  red_byte,
  output logic [7:0]  green_byte,
  output logic [7:0]  blue_byte,
  output logic [7:0]  alpha_byte
);
  import hdrp_pkg::*;

  typedef struct packed {
    logic       hdr;
    logic [1:0] alpha;
    logic [7:0] sdr_r;
    logic [7:0] sdr_g;
    logic [7:0] sdr_b;
  } side_t;

  logic               hdr10_enable;
  logic [WHITE_W-1:0] paper_white_nits;
  logic [WHITE_W-1:0] white_eff;

  logic [NSTAGE-1:0]  vld;
  logic [NSTAGE-1:0]  vld_next;
  logic [NSTAGE:0]    rdy;
  side_t              side [NSTAGE];
  side_t              side_in;
  logic [PQ_W-1:0]    pq_lvl [3];
  logic [7:0]         hdr_byte [3];

  // plain 10-bit to 8-bit rescale: (c*255+511)/1023 without a divider
  function automatic logic [7:0] sdr_scale(input logic [9:0] c);
    logic [17:0] x;
    logic [10:0] r;
    x = 18'(c * 18'd255) + 18'd511;
    r = {1'b0, x[9:0]} + {3'b0, x[17:10]};
    return 8'(x[17:10] + 8'(r >= 11'd1023));
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr10_enable     <= 1'b0;
      paper_white_nits <= 14'd300;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_HDR10_ENABLE: hdr10_enable     <= pwdata[0];
        REG_PAPER_WHITE:  paper_white_nits <= pwdata[WHITE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HDR10_ENABLE: prdata = {31'd0, hdr10_enable};
      REG_PAPER_WHITE:  prdata = {18'd0, paper_white_nits};
      default:          prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign white_eff = (paper_white_nits == '0) ? 14'd1 : paper_white_nits;

  // valid bits and per-stage advance
  assign rdy[NSTAGE] = result_ready;
  for (genvar i = 0; i < NSTAGE; i++) begin : g_rdy
    assign rdy[i] = !vld[i] || rdy[i+1];
  end
  assign vld_next = {vld[NSTAGE-2:0], pixel_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NSTAGE; i++) begin
        if (rdy[i]) vld[i] <= vld_next[i];
      end
    end
  end

  assign pixel_ready  = rdy[0];
  assign result_valid = vld[NSTAGE-1];

  // stage 0: PQ ROM per colour, side band for the plain path and alpha
  assign side_in = '{hdr:   hdr10_enable,
                     alpha: packed_pixel[31:30],
                     sdr_r: sdr_scale(packed_pixel[9:0]),
                     sdr_g: sdr_scale(packed_pixel[19:10]),
                     sdr_b: sdr_scale(packed_pixel[29:20])};

  always_ff @(posedge clk) begin
    if (rdy[0]) pq_lvl[0] <= PQ_TABLE[packed_pixel[9:0]];
  end
  always_ff @(posedge clk) begin
    if (rdy[0]) pq_lvl[1] <= PQ_TABLE[packed_pixel[19:10]];
  end
  always_ff @(posedge clk) begin
    if (rdy[0]) pq_lvl[2] <= PQ_TABLE[packed_pixel[29:20]];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) side[0] <= side_in;
  end
  for (genvar i = 1; i < NSTAGE; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rdy[i]) side[i] <= side[i-1];
    end
  end

  // colour lanes
  for (genvar k = 0; k < 3; k++) begin : g_lane
    hdrp_chan u_chan (
      .clk       (clk),
      .load      (rdy[NSTAGE-1:0]),
      .coef_r    (COEF[k][0]),
      .coef_g    (COEF[k][1]),
      .coef_b    (COEF[k][2]),
      .white     (white_eff),
      .pq_r      (pq_lvl[0]),
      .pq_g      (pq_lvl[1]),
      .pq_b      (pq_lvl[2]),
      .chan_byte (hdr_byte[k])
    );
  end

  // result beat
  assign red_byte   = side[NSTAGE-1].hdr ? hdr_byte[0] : side[NSTAGE-1].sdr_r;
  assign green_byte = side[NSTAGE-1].hdr ? hdr_byte[1] : side[NSTAGE-1].sdr_g;
  assign blue_byte  = side[NSTAGE-1].hdr ? hdr_byte[2] : side[NSTAGE-1].sdr_b;
  assign alpha_byte = {4{side[NSTAGE-1].alpha}};

  // checks
  `ASSERT_ALWAYS(a_white_nonzero, white_eff != 14'd0)
  `ASSERT_NEXT(a_in_lands, pixel_valid && pixel_ready, vld[0])
  `ASSERT_IMPLIES(a_full_stall, (&vld) && !result_ready, !pixel_ready)
  `ASSERT_NEXT(a_drains, vld[NSTAGE-2] && !vld[NSTAGE-1], vld[NSTAGE-1])

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for the HDR10 pixel to 8-bit sRGBA converter: random pixels, scoreboard check
`timescale 1ns / 100ps
`default_nettype none

// Holds the converter's register copy, the curve predictor and the queue of expected bytes
class rgba_scoreboard;
  typedef struct {
    logic [31:0] px;
    logic [7:0]  r, g, b, a;
  } rgba_t;

  rgba_t       pending[$];
  bit          hdr_on;
  int unsigned white;
  longint unsigned pq_nits[1024];
  longint unsigned srgb_cache[longint unsigned];
  int          errors;
  int          checked;

  function new();
    hdr_on = 0;
    white  = 300;
    for (int c = 0; c < 1024; c++) pq_nits[c] = pq_decode(c);
  endfunction

  // log2 in Q28 by repeated squaring of the mantissa
  function longint unsigned log2_q28(longint unsigned x);
    longint unsigned m, f;
    int msb;
    f = 0;
    msb = 0;
    if (x == 0) return 0;
    for (int i = 0; i < 64; i++) if (x[i]) msb = i;
    m = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
    for (int i = 1; i <= 28; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f = f | (64'd1 << (28 - i));
      end
    end
    return (longint'(msb) << 28) | f;
  endfunction

  // 2^-t, t in Q28, Q30 result, 20-term series
  function longint unsigned pow2_neg(longint unsigned t);
    longint unsigned ip, z, term;
    longint acc;
    ip = t >> 28;
    z = ((t & 64'h0FFF_FFFF) * 64'd744261118) >> 28;
    term = 64'd1 << 30;
    acc = 64'sd1 << 30;
    if (ip >= 40) return 0;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * z) >> 30) / k;
      if (k % 2) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    return longint'(unsigned'(acc)) >> ip;
  endfunction

  // ST 2084 code to nits, Q14.16
  function longint unsigned pq_decode(int c);
    longint unsigned mag, ep, num, den, y, ln, ld;
    if (c == 0) return 0;
    mag = log2_q28(1023) - log2_q28(c);
    ep = pow2_neg(mag * 32 / 2523);
    if (ep <= (64'd3424 << 18)) return 0;
    num = ep - (64'd3424 << 18);
    den = (64'd2413 << 23) - ((64'd2392 * ep) >> 7);
    ln = log2_q28(num);
    ld = log2_q28(den);
    mag = (ld > ln) ? (ld - ln) : 0;
    y = pow2_neg(mag * 8192 / 1305);
    return ((y * 10000 + 8192) >> 14) & 64'hFFFF_FFFF;
  endfunction

  // sRGB encode of linear Q0.16, cached per value
  function longint unsigned srgb_encode(longint unsigned v);
    longint unsigned p;
    longint s;
    if (srgb_cache.exists(v)) return srgb_cache[v];
    if (v <= 205) s = (1292 * v + 50) / 100;
    else begin
      p = pow2_neg(((64'd16 << 28) - log2_q28(v)) * 5 / 12);
      s = (longint'(1055 * p) - longint'(55 * (64'd1 << 30)) + longint'(64'd1000 << 13))
          / longint'(64'd1000 << 14);
      if (s < 0) s = 0;
      if (s > 65536) s = 65536;
    end
    srgb_cache[v] = s;
    return s;
  endfunction

  function logic [7:0] hdr_lane(longint k0, longint k1, longint k2, int r, int g, int b);
    longint acc;
    longint unsigned lin, w;
    w = (white == 0) ? 1 : white;
    acc = k0 * longint'(pq_nits[r]) + k1 * longint'(pq_nits[g]) + k2 * longint'(pq_nits[b]);
    if (acc <= 0) lin = 0;
    else lin = (longint'(unsigned'(acc)) + (w << 19)) / (w << 20);
    if (lin > 65536) lin = 65536;
    return 8'((srgb_encode(lin) * 255 + 32768) >> 16);
  endfunction

  function void note_pixel(logic [31:0] px);
    rgba_t e;
    int r, g, b;
    r = px[9:0];
    g = px[19:10];
    b = px[29:20];
    e.px = px;
    if (hdr_on) begin
      e.r = hdr_lane(1741151, -616186, -76389, r, g, b);
      e.g = hdr_lane(-130600, 1187932, -8755, r, g, b);
      e.b = hdr_lane(-19033, -105465, 1173073, r, g, b);
    end else begin
      e.r = 8'((r * 255 + 511) / 1023);
      e.g = 8'((g * 255 + 511) / 1023);
      e.b = 8'((b * 255 + 511) / 1023);
    end
    e.a = 8'(px[31:30] * 85);
    pending.push_back(e);
  endfunction

  function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    rgba_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat %h %h %h %h", r, g, b, a);
      return;
    end
    e = pending.pop_front();
    checked++;
    if (r !== e.r || g !== e.g || b !== e.b || a !== e.a) begin
      errors++;
      if (errors <= 10)
        $display("mismatch px=%h exp %h %h %h %h got %h %h %h %h",
                 e.px, e.r, e.g, e.b, e.a, r, g, b, a);
    end
  endfunction
endclass

module testbench;
  localparam logic [2:0] ADDR_HDR10 = 3'd0;
  localparam logic [2:0] ADDR_WHITE = 3'd4;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        pixel_valid, pixel_ready;
  logic [31:0] packed_pixel;
  logic        result_valid, result_ready;
  logic [7:0]  red_byte, green_byte, blue_byte, alpha_byte;

  rgba_scoreboard sb;
  bit          calm;       // no idling on either side
  bit          hold_req;   // ask the receiver for a long stall
  int          stall_left;

  hdr10_pixel_to_srgb8_top uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // generous cap on the run
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // result side: check each beat, then choose next ready
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 0;
      stall_left   <= 0;
    end else begin
      if (result_valid && result_ready)
        sb.check_result(red_byte, green_byte, blue_byte, alpha_byte);
      if (hold_req && stall_left == 0) begin
        stall_left   <= 300;
        result_ready <= 0;
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        result_ready <= (stall_left == 1);
      end else if (!calm && $urandom_range(0, 9) < 2) begin
        stall_left   <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
        result_ready <= 0;
      end else begin
        result_ready <= 1;
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    if (addr == ADDR_HDR10) sb.hdr_on = data[0];
    else sb.white = data[13:0];
  endtask

  // one pixel beat, optionally after an idle gap
  task automatic send_pixel(logic [31:0] px);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 9) >= 6)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      pixel_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid  <= 1;
    packed_pixel <= px;
    do @(posedge clk); while (!pixel_ready);
    sb.note_pixel(px);
  endtask

  // drain, then let the pipe settle before touching registers
  task automatic drain();
    pixel_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [31:0] px;
    px = $urandom;
    case ($urandom_range(0, 5))
      0: px[29:0] = px[29:0] & 30'h0FF3_FCFF;   // dim codes
      1: px[29:0] = px[29:0] | 30'h3C0F_03C0;   // bright codes
      2: px[19:0] = 20'h0;                      // blue only
      default: ;
    endcase
    return px;
  endfunction

  task automatic directed_set();
    logic [31:0] pats[14] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_03FF, 32'h000F_FC00,
                              32'h3FF0_0000, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                              32'h3FFF_FC00, 32'h000F_FFFF, 32'h3FF0_03FF, 32'h2008_0200,
                              32'h0000_0001, 32'h1FF7_FDFF};
    foreach (pats[i]) send_pixel(pats[i]);
  endtask

  initial begin
    int wset[8] = '{300, 300, 1, 10000, 0, 16383, 100, 300};
    int hset[8] = '{0, 1, 1, 1, 1, 1, 1, 0};
    sb = new();
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    pixel_valid = 0; packed_pixel = '0;
    calm = 0; hold_req = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 6) wset[ph] = $urandom_range(20, 2000);
      reg_write(ADDR_WHITE, wset[ph] | ($urandom & 32'hFFFF_C000));
      reg_write(ADDR_HDR10, hset[ph] | ($urandom & 32'hFFFF_FFFE));
      if (ph < 2 || ph == 4) directed_set();
      for (int n = 0; n < 120; n++) begin
        calm = (n >= 40 && n < 60);
        if (ph == 1 && n == 70) hold_req = 1;
        if (stall_left != 0) hold_req = 0;
        send_pixel(rand_pixel());
      end
      calm = 0;
      hold_req = 0;
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

`default_nettype wire
